// ----- rtl/core/modular_arith_alu_defines.svh -----
// Assertion macros shared by the checker of the modular arithmetic unit.
// Depends on nothing; included by maa_checker.sv.
`ifndef MODULAR_ARITH_ALU_DEFINES_SVH
`define MODULAR_ARITH_ALU_DEFINES_SVH

// Implication checked in the same cycle.
`define MAA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular_arith_alu: same-cycle check failed");

// Implication checked in the next cycle.
`define MAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular_arith_alu: next-cycle check failed");

`endif

// ----- rtl/core/maa_pkg.sv -----
// Shared types and constants of the modular arithmetic unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package maa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int DATA_W         = 32;
  localparam logic [DATA_W-1:0] MOD_RESET = 32'hFFFF_FFFB;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_NEG = 3'd2,
    CMD_MUL = 3'd3,
    CMD_INV = 3'd4,
    CMD_DIV = 3'd5,
    CMD_REM = 3'd6,
    CMD_XOR = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_ZERO    = 2'd1,
    STS_GCD     = 2'd2,
    STS_REMZERO = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_EXEC,
    S_EU_CHK,
    S_EU_DIV,
    S_EU_MUL,
    S_MUL_FIN,
    S_REM_WAIT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/maa_div.sv -----
// Bit-serial restoring divider: quotient and remainder, one bit per cycle.
// Depends on maa_pkg.
`default_nettype none
module maa_div import maa_pkg::*; #(
  parameter int W = VALUE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W:0]   n,
  input  wire logic [W:0]   d,
  output logic              done,
  output logic [W:0]        quo,
  output logic [W:0]        rem
);
  localparam int CW = $clog2(W + 2);

  logic [W:0]    n_r, d_r, r_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [W+1:0]  tr, diff;
  logic          ge;

  always_comb begin
    tr   = {r_r, n_r[W]};
    diff = tr - {1'b0, d_r};
    ge   = tr >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        n_r   <= n;
        d_r   <= d;
        r_r   <= '0;
      end else if (run_r) begin
        r_r   <= ge ? diff[W:0] : tr[W:0];
        n_r   <= {n_r[W-1:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = n_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

// ----- rtl/core/maa_mul.sv -----
// Bit-serial modular multiplier (double then conditional add, MSB first).
// Depends on maa_pkg.
`default_nettype none
module maa_mul import maa_pkg::*; #(
  parameter int W = VALUE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W:0]   x,
  input  wire logic [W-1:0] y,
  input  wire logic [W:0]   m,
  output logic              done,
  output logic [W-1:0]      prod
);
  localparam int CW = $clog2(W + 2);

  logic [W:0]    x_r, m_r;
  logic [W-1:0]  y_r, acc_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, ph_r, done_r;
  logic [W:0]    wide, red;

  // phase 0 doubles the accumulator, phase 1 adds y when the scanned bit is set
  always_comb begin
    if (!ph_r) wide = {acc_r, 1'b0};
    else       wide = {1'b0, acc_r} + (x_r[W] ? {1'b0, y_r} : '0);
    red = (wide >= m_r) ? wide - m_r : wide;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ph_r  <= 1'b0;
        cnt_r <= '0;
        x_r   <= x;
        y_r   <= y;
        m_r   <= m;
        acc_r <= '0;
      end else if (run_r) begin
        acc_r <= red[W-1:0];
        ph_r  <= ~ph_r;
        if (ph_r) begin
          x_r   <= {x_r[W-1:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(W)) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ----- rtl/core/modular_arith_alu.sv -----
// Modular arithmetic unit: add, sub, neg, mul, inverse, divide, remainder
// and xor modulo the configured modulus (0 acts as 2^VALUE_BITS). An item is
// taken when start is high and busy is low; busy then stays high until the
// result appears on out_result_value/out_status_code for exactly one cycle
// with out_valid, and the receiver cannot stall it. All work runs through one
// bit-serial divider and one bit-serial modular multiplier, W = VALUE_BITS.
// Both operands are first reduced by the divider, a and then b. Then add,
// sub and neg finish in S_EXEC; mul runs the multiplier; remainder and xor one more division.
// Inverse runs extended Euclid, each step one division (S_EU_DIV) and one
// modular multiply (S_EU_MUL) plus a check state (S_EU_CHK), with up to
// about 1.44*W steps. Divide adds one more multiply. Configuration
// (cfg_we/cfg_wdata) must be written only while busy is low.
// Depends on maa_pkg, maa_div and maa_mul.
`default_nettype none
module modular_arith_alu import maa_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_command,
  input  wire logic [DATA_W-1:0] in_operand_a,
  input  wire logic [DATA_W-1:0] in_operand_b,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_result_value,
  output logic [1:0]             out_status_code
);
  localparam int W = VALUE_BITS;

  // registers
  logic [DATA_W-1:0] modulus_r;
  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [W-1:0]      braw_r, braw_nxt;
  logic [W:0]        mod_r, mod_nxt;
  logic [W-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [W:0]        r_r, r_nxt;             // Euclid remainder, can equal m
  logic [W-1:0]      nr_r, nr_nxt;
  logic [W-1:0]      t_r, t_nxt, nt_r, nt_nxt; // Bezout coefficients as residues
  logic [W:0]        rr_r, rr_nxt;
  logic [W-1:0]      res_r, res_nxt;
  status_t           st_r, st_nxt;
  logic              ov_r, ov_nxt;

  // serial units
  logic         div_start, div_done, mul_start, mul_done;
  logic [W:0]   div_n, div_d, div_quo, div_rem, mul_x;
  logic [W-1:0] mul_y, mul_prod;

  // single-cycle helpers
  logic [W:0]   sum, dif, negv, tsub;
  logic [W-1:0] mod_low;

  maa_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .n(div_n), .d(div_d),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  maa_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
    .m(mod_r), .done(mul_done), .prod(mul_prod)
  );

  always_comb begin
    mod_low = modulus_r[W-1:0];
    sum  = {1'b0, a_r} + {1'b0, b_r};
    if (sum >= mod_r) sum = sum - mod_r;
    dif  = (a_r >= b_r) ? {1'b0, a_r} - {1'b0, b_r} : {1'b0, a_r} + mod_r - {1'b0, b_r};
    negv = (a_r == '0) ? '0 : mod_r - {1'b0, a_r};
    // t - q*nt mod m, with q*nt already reduced in mul_prod
    tsub = (t_r >= mul_prod) ? {1'b0, t_r} - {1'b0, mul_prod}
                             : {1'b0, t_r} + mod_r - {1'b0, mul_prod};
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    braw_nxt  = braw_r;
    mod_nxt   = mod_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    r_nxt     = r_r;
    nr_nxt    = nr_r;
    t_nxt     = t_r;
    nt_nxt    = nt_r;
    rr_nxt    = rr_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    ov_nxt    = 1'b0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = mod_r;
    mul_start = 1'b0;
    mul_x     = '0;
    mul_y     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_t'(in_command);
          braw_nxt  = in_operand_b[W-1:0];
          mod_nxt   = (mod_low == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_low};
          div_start = 1'b1;
          div_n     = {1'b0, in_operand_a[W-1:0]};
          div_d     = (mod_low == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_low};
          state_nxt = S_RED_A;
        end
      end
      S_RED_A: begin
        if (div_done) begin
          a_nxt     = div_rem[W-1:0];
          div_start = 1'b1;
          div_n     = {1'b0, braw_r};
          state_nxt = S_RED_B;
        end
      end
      S_RED_B: begin
        if (div_done) begin
          b_nxt     = div_rem[W-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt = STS_OK;
        case (cmd_r)
          CMD_ADD: begin res_nxt = sum[W-1:0];  ov_nxt = 1'b1; state_nxt = S_IDLE; end
          CMD_SUB: begin res_nxt = dif[W-1:0];  ov_nxt = 1'b1; state_nxt = S_IDLE; end
          CMD_NEG: begin res_nxt = negv[W-1:0]; ov_nxt = 1'b1; state_nxt = S_IDLE; end
          CMD_MUL: begin
            mul_start = 1'b1;
            mul_x     = {1'b0, a_r};
            mul_y     = b_r;
            state_nxt = S_MUL_FIN;
          end
          CMD_INV, CMD_DIV: begin
            if (((cmd_r == CMD_INV) ? a_r : b_r) == '0) begin
              res_nxt   = '0;
              st_nxt    = STS_ZERO;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              r_nxt     = mod_r;
              nr_nxt    = (cmd_r == CMD_INV) ? a_r : b_r;
              t_nxt     = '0;
              nt_nxt    = W'(1);
              state_nxt = S_EU_CHK;
            end
          end
          CMD_REM: begin
            if (b_r == '0) begin
              res_nxt   = '0;
              st_nxt    = STS_REMZERO;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              div_start = 1'b1;
              div_n     = {1'b0, a_r};
              div_d     = {1'b0, b_r};
              state_nxt = S_REM_WAIT;
            end
          end
          CMD_XOR: begin
            div_start = 1'b1;
            div_n     = {1'b0, a_r ^ b_r};
            state_nxt = S_REM_WAIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_EU_CHK: begin
        if (nr_r == '0) begin
          if (r_r > (W+1)'(1)) begin
            res_nxt   = '0;
            st_nxt    = STS_GCD;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (cmd_r == CMD_INV) begin
            res_nxt   = t_r;
            st_nxt    = STS_OK;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            mul_start = 1'b1;
            mul_x     = {1'b0, a_r};
            mul_y     = t_r;
            state_nxt = S_MUL_FIN;
          end
        end else begin
          div_start = 1'b1;
          div_n     = r_r;
          div_d     = {1'b0, nr_r};
          state_nxt = S_EU_DIV;
        end
      end
      S_EU_DIV: begin
        if (div_done) begin
          rr_nxt    = div_rem;
          mul_start = 1'b1;
          mul_x     = div_quo;
          mul_y     = nt_r;
          state_nxt = S_EU_MUL;
        end
      end
      S_EU_MUL: begin
        if (mul_done) begin
          t_nxt     = nt_r;
          nt_nxt    = tsub[W-1:0];
          r_nxt     = {1'b0, nr_r};
          nr_nxt    = rr_r[W-1:0];
          state_nxt = S_EU_CHK;
        end
      end
      S_MUL_FIN: begin
        if (mul_done) begin
          res_nxt   = mul_prod;
          st_nxt    = STS_OK;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REM_WAIT: begin
        if (div_done) begin
          res_nxt   = div_rem[W-1:0];
          st_nxt    = STS_OK;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      modulus_r <= MOD_RESET;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) modulus_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    braw_r <= braw_nxt;
    mod_r  <= mod_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    r_r    <= r_nxt;
    nr_r   <= nr_nxt;
    t_r    <= t_nxt;
    nt_r   <= nt_nxt;
    rr_r   <= rr_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_result_value = DATA_W'(res_r);
  assign out_status_code  = st_r;
endmodule
`default_nettype wire

// ----- rtl/core/maa_checker.sv -----
// Port-level checks of the modular arithmetic unit, bound to its top level.
// Depends on maa_pkg and modular_arith_alu_defines.svh.
`default_nettype none
`include "modular_arith_alu_defines.svh"
module maa_checker import maa_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [DATA_W-1:0] out_result_value,
  input wire logic [1:0]        out_status_code
);
  logic err_out;

  assign err_out = out_valid && (out_status_code != STS_OK);

  `MAA_ASSERT_NOW(a_err_zero, clk, rst_n, err_out, out_result_value == '0)
  `MAA_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
  `MAA_ASSERT_NEXT(a_one_pulse, clk, rst_n, out_valid, !out_valid)
  `MAA_ASSERT_NOW(a_done_idle, clk, rst_n, out_valid, !busy)
endmodule

bind modular_arith_alu maa_checker u_maa_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_result_value(out_result_value), .out_status_code(out_status_code)
);
`default_nettype wire
